// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/apls_eq_pkg.sv =====
package apls_eq_pkg;

	// Number of channels with their own filter state.
	localparam int CHANNELS = 2;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths.
	localparam int SMP_W   = 24;
	localparam int CHN_W   = 4;
	localparam int COEF_W  = 24;
	localparam int GAIN_W  = 28;
	localparam int ST_W    = 28;
	localparam int OPA_W   = 28;
	localparam int OPB_W   = 29;
	localparam int PROD_W  = OPA_W + OPB_W;
	localparam int TERM_W  = PROD_W - 22;
	localparam int ACC_W   = 38;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_BAND_C     = 3'd0;
	localparam logic [2:0] REG_BAND_D     = 3'd1;
	localparam logic [2:0] REG_SHELF_COEF = 3'd2;
	localparam logic [2:0] REG_PEAK_GAIN  = 3'd3;
	localparam logic [2:0] REG_SHELF_GAIN = 3'd4;

	// Program length and step counter.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(9);

	typedef enum logic [2:0] {
		A_C, A_D, A_K, A_PG, A_SG
	} opa_sel_t;

	typedef enum logic [2:0] {
		B_X, B_B1, B_S1, B_X1_MINUS_B1, B_X_MINUS_ACC, B_X_PLUS_ACC
	} opb_sel_t;

	typedef enum logic [2:0] {
		ACC_NOP, ACC_LOAD_ADD, ACC_LOAD_SUB, ACC_ADD, ACC_SUB, ACC_FIN
	} acc_op_t;

	typedef enum logic [1:0] {
		BASE_X, BASE_X1, BASE_I1
	} base_sel_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_INNER, WR_BAND, WR_SHELF
	} wr_sel_t;

	// One control word: operand load, accumulate stage, capture and writeback.
	typedef struct packed {
		logic      ld;
		opa_sel_t  a_sel;
		opb_sel_t  b_sel;
		logic      shr23;
		acc_op_t   acc_op;
		base_sel_t base_sel;
		wr_sel_t   wr_sel;
		logic      wb;
		logic      last;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		ld: 1'b0, a_sel: A_C, b_sel: B_X, shr23: 1'b0, acc_op: ACC_NOP,
		base_sel: BASE_X, wr_sel: WR_NONE, wb: 1'b0, last: 1'b0
	};

	// The program. An operand pair loaded at step s is multiplied at step s+1
	// and its rounded product is accumulated at step s+2.
	function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = CTRL_NOP;
		unique case (step)
			STEP_W'(0): begin
				w.ld = 1'b1; w.a_sel = A_C; w.b_sel = B_B1;
			end
			STEP_W'(1): begin
				w.ld = 1'b1; w.a_sel = A_C; w.b_sel = B_X;
			end
			STEP_W'(2): begin
				w.ld = 1'b1; w.a_sel = A_D; w.b_sel = B_X1_MINUS_B1;
				w.acc_op = ACC_LOAD_ADD; w.base_sel = BASE_X1;
			end
			STEP_W'(3): begin
				w.ld = 1'b1; w.a_sel = A_K; w.b_sel = B_X;
				w.acc_op = ACC_LOAD_SUB; w.base_sel = BASE_I1; w.wr_sel = WR_INNER;
			end
			STEP_W'(4): begin
				w.ld = 1'b1; w.a_sel = A_K; w.b_sel = B_S1;
				w.acc_op = ACC_ADD;
			end
			STEP_W'(5): begin
				w.ld = 1'b1; w.a_sel = A_PG; w.b_sel = B_X_MINUS_ACC;
				w.acc_op = ACC_LOAD_ADD; w.base_sel = BASE_X1; w.wr_sel = WR_BAND;
			end
			STEP_W'(6): begin
				w.acc_op = ACC_SUB;
			end
			STEP_W'(7): begin
				w.ld = 1'b1; w.a_sel = A_SG; w.b_sel = B_X_PLUS_ACC;
				w.shr23 = 1'b1; w.acc_op = ACC_LOAD_ADD; w.base_sel = BASE_X;
				w.wr_sel = WR_SHELF;
			end
			STEP_W'(8): begin
				w.wb = 1'b1;
			end
			STEP_W'(9): begin
				w.shr23 = 1'b1; w.acc_op = ACC_FIN; w.last = 1'b1;
			end
			default: begin
				w = CTRL_NOP;
			end
		endcase
		return w;
	endfunction

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'({1'b0, {(ST_W-1){1'b1}}}));
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			return {1'b0, {(ST_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(ST_W-1){1'b0}}};
		end
		return v[ST_W-1:0];
	endfunction

	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'({1'b0, {(SMP_W-1){1'b1}}}));
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			return {1'b0, {(SMP_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(SMP_W-1){1'b0}}};
		end
		return v[SMP_W-1:0];
	endfunction

endpackage

// ===== design/allpass_peaking_low_shelf_eq.sv =====
// A request runs the ten-step program, which puts all seven products of a sample
// through the one shared 28 x 29 multiplier; the result is registered at the output.
// The last step waits until the output register is free or being emptied.
// The next sample is taken at the same edge as the last step of the previous one.
// Reset (arst_n low, asynchronous) clears the coefficients, gains, all channel
// state, the sequencer and the output valid flag.
`include "assert_macros.svh"

module allpass_peaking_low_shelf_eq (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [apls_eq_pkg::PADDR_W-1:0]     paddr,
	input  logic [apls_eq_pkg::PDATA_W-1:0]     pwdata,
	output logic [apls_eq_pkg::PDATA_W-1:0]     prdata,
	output logic                                pready,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [apls_eq_pkg::SMP_W-1:0]       s_tdata,  // [23:0] sample_in
	input  logic [apls_eq_pkg::CHN_W-1:0]       s_tuser,  // [3:0] channel
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [apls_eq_pkg::SMP_W-1:0]       m_tdata,  // [23:0] sample_out
	output logic [apls_eq_pkg::CHN_W-1:0]       m_tuser   // [3:0] channel_out
);
	import apls_eq_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. The bus must write them only while the filter is
	// idle, which the block does not enforce; the datapath reads them directly.
	// ------------------------------------------------------------------
	logic signed [COEF_W-1:0] band_coef_c_q;
	logic signed [COEF_W-1:0] band_coef_d_q;
	logic signed [COEF_W-1:0] shelf_coef_q;
	logic signed [GAIN_W-1:0] peak_gain_q;
	logic signed [GAIN_W-1:0] shelf_gain_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_coef_c_q <= '0;
			band_coef_d_q <= '0;
			shelf_coef_q  <= '0;
			peak_gain_q   <= '0;
			shelf_gain_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BAND_C:     band_coef_c_q <= pwdata[COEF_W-1:0];
				REG_BAND_D:     band_coef_d_q <= pwdata[COEF_W-1:0];
				REG_SHELF_COEF: shelf_coef_q  <= pwdata[COEF_W-1:0];
				REG_PEAK_GAIN:  peak_gain_q   <= pwdata[GAIN_W-1:0];
				REG_SHELF_GAIN: shelf_gain_q  <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the register value sign-extended to the bus width.
	always_comb begin
		unique case (cfg_idx)
			REG_BAND_C:     prdata = PDATA_W'(band_coef_c_q);
			REG_BAND_D:     prdata = PDATA_W'(band_coef_d_q);
			REG_SHELF_COEF: prdata = PDATA_W'(shelf_coef_q);
			REG_PEAK_GAIN:  prdata = PDATA_W'(peak_gain_q);
			REG_SHELF_GAIN: prdata = PDATA_W'(shelf_gain_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer. A request starts the program at step zero; every step
	// reads its control word from the program table. The last step only
	// completes once the output register is free or being emptied, and the
	// next request is taken at that same edge.
	// ------------------------------------------------------------------
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	ctrl_t             ctrl;
	logic              out_free;
	logic              step_go;
	logic              fin_go;
	logic              in_go;

	assign ctrl     = ctrl_rom(step_q);
	assign out_free = !m_tvalid || m_tready;
	assign step_go  = busy_q && (!ctrl.last || out_free);
	assign fin_go   = step_go && ctrl.last;
	assign s_tready = !busy_q || fin_go;
	assign in_go    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_go) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (fin_go) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (step_go) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Per-channel filter state, cleared at reset. A request takes a copy of
	// its channel's four words; the program writes the new ones back one
	// step before it finishes, so a request taken at the final edge already
	// sees them.
	// ------------------------------------------------------------------
	logic signed [ST_W-1:0] prev_input_q     [CHANNELS];
	logic signed [ST_W-1:0] prev_band_out_q  [CHANNELS];
	logic signed [ST_W-1:0] band_inner_q     [CHANNELS];
	logic signed [ST_W-1:0] prev_shelf_out_q [CHANNELS];

	logic signed [SMP_W-1:0] x_q;
	logic [CHN_W-1:0]        ch_q;
	logic                    bypass_q;
	logic signed [ST_W-1:0]  x1_q;
	logic signed [ST_W-1:0]  b1_q;
	logic signed [ST_W-1:0]  i1_q;
	logic signed [ST_W-1:0]  s1_q;
	logic signed [ST_W-1:0]  band_q;
	logic signed [ST_W-1:0]  inner_q;
	logic signed [ST_W-1:0]  shelf_q;

	logic [CH_W-1:0] in_idx;
	logic [CH_W-1:0] wb_idx;
	logic            in_range;

	assign in_idx   = s_tuser[CH_W-1:0];
	assign wb_idx   = ch_q[CH_W-1:0];
	assign in_range = {1'b0, s_tuser} < (CHN_W + 1)'(CHANNELS);

	always_ff @(posedge clk) begin
		if (in_go) begin
			x_q  <= s_tdata;
			ch_q <= s_tuser;
			x1_q <= prev_input_q[in_idx];
			b1_q <= prev_band_out_q[in_idx];
			i1_q <= band_inner_q[in_idx];
			s1_q <= prev_shelf_out_q[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else if (in_go) begin
			bypass_q <= !in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_input_q[i]     <= '0;
				prev_band_out_q[i]  <= '0;
				band_inner_q[i]     <= '0;
				prev_shelf_out_q[i] <= '0;
			end
		end else if (step_go && ctrl.wb && !bypass_q) begin
			prev_input_q[wb_idx]     <= ST_W'(x_q);
			prev_band_out_q[wb_idx]  <= band_q;
			band_inner_q[wb_idx]     <= inner_q;
			prev_shelf_out_q[wb_idx] <= shelf_q;
		end
	end

	// ------------------------------------------------------------------
	// Datapath: operand registers, one multiplier with its product
	// register, then rounding and a single accumulator.
	// ------------------------------------------------------------------
	logic signed [OPA_W-1:0]  opa_q;
	logic signed [OPB_W-1:0]  opb_q;
	logic signed [OPA_W-1:0]  opa_d;
	logic signed [OPB_W-1:0]  opb_d;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ST_W-1:0]   acc_sat;
	logic signed [PROD_W-1:0] rnd;
	logic signed [TERM_W-1:0] term;
	logic signed [ACC_W-1:0]  term_x;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  fin_sum;

	// The band and shelf outputs are fed back straight from the accumulator
	// in the step where it holds them.
	assign acc_sat = sat_st(acc_q);

	always_comb begin
		unique case (ctrl.a_sel)
			A_C:     opa_d = OPA_W'(band_coef_c_q);
			A_D:     opa_d = OPA_W'(band_coef_d_q);
			A_K:     opa_d = OPA_W'(shelf_coef_q);
			A_PG:    opa_d = peak_gain_q;
			A_SG:    opa_d = shelf_gain_q;
			default: opa_d = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.b_sel)
			B_X:           opb_d = OPB_W'(x_q);
			B_B1:          opb_d = OPB_W'(b1_q);
			B_S1:          opb_d = OPB_W'(s1_q);
			B_X1_MINUS_B1: opb_d = OPB_W'(x1_q) - OPB_W'(b1_q);
			B_X_MINUS_ACC: opb_d = OPB_W'(x_q) - OPB_W'(acc_sat);
			B_X_PLUS_ACC:  opb_d = OPB_W'(x_q) + OPB_W'(acc_sat);
			default:       opb_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (step_go && ctrl.ld) begin
			opa_q <= opa_d;
			opb_q <= opb_d;
		end
		if (step_go) begin
			prod_q <= PROD_W'(opa_q) * PROD_W'(opb_q);
		end
	end

	// Round to nearest with ties towards plus infinity: add half, then
	// take the arithmetic shift by 22 (coefficients) or 23 (gains, which
	// carry the factor of one half).
	assign rnd  = prod_q + (ctrl.shr23 ? PROD_W'(64'sd1 <<< 22) : PROD_W'(64'sd1 <<< 21));
	assign term = ctrl.shr23 ? TERM_W'(signed'(rnd[PROD_W-1:23])) : rnd[PROD_W-1:22];
	assign term_x = ACC_W'(term);

	always_comb begin
		unique case (ctrl.base_sel)
			BASE_X:  base = ACC_W'(x_q);
			BASE_X1: base = ACC_W'(x1_q);
			BASE_I1: base = ACC_W'(i1_q);
			default: base = '0;
		endcase
	end

	assign fin_sum = acc_q + term_x;

	always_ff @(posedge clk) begin
		if (step_go) begin
			unique case (ctrl.acc_op)
				ACC_LOAD_ADD: acc_q <= base + term_x;
				ACC_LOAD_SUB: acc_q <= base - term_x;
				ACC_ADD:      acc_q <= acc_q + term_x;
				ACC_SUB:      acc_q <= acc_q - term_x;
				ACC_NOP, ACC_FIN: begin
				end
				default: begin
				end
			endcase
			unique case (ctrl.wr_sel)
				WR_INNER: inner_q <= acc_sat;
				WR_BAND:  band_q  <= acc_sat;
				WR_SHELF: shelf_q <= acc_sat;
				WR_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register. A channel outside the configured range passes its
	// sample through unchanged.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fin_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tdata <= bypass_q ? x_q : sat_smp(fin_sum);
			m_tuser <= ch_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`ASSERT_SAME(a_step_in_program, clk, arst_n, busy_q, step_q <= LAST_STEP, "step counter ran past the program")
	`ASSERT_NEXT(a_req_starts_program, clk, arst_n, in_go, busy_q && (step_q == '0), "request did not start the program")
	`ASSERT_NEXT(a_result_from_last_step, clk, arst_n, !(busy_q && (step_q == LAST_STEP)), !$rose(m_tvalid), "result offered without a finished program")
endmodule
